// ----- rtl/kss_pkg.sv -----
// ============================================================================
// Key set package
// Shared types, codes and constants of the two-level sorted key set unit.
// ============================================================================
package kss_pkg;

   localparam int KEY_W        = 32;
   localparam int PAY_PORT_W   = 32;
   localparam int TOTAL_W      = 11;
   localparam int LIMIT_W      = 5;
   localparam int KIND_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int LIMIT_RESET  = 16;

   localparam int STAGE_DEPTH_DEF  = 16;
   localparam int MAIN_DEPTH_DEF   = 1024;
   localparam int PAYLOAD_BITS_DEF = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_POP    = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SINIT,
      S_PROBE,
      S_STEP,
      S_CHECK,
      S_MRG_RD,
      S_MRG_STEP,
      S_INS_RD,
      S_INS_STEP,
      S_POP_RD,
      S_POP_STEP,
      S_CLEAR,
      S_SEND
   } state_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_SINIT,
      OP_MINIT,
      OP_PROBE,
      OP_STEP,
      OP_FULL,
      OP_MRG_INIT,
      OP_MRG_RD,
      OP_MRG_STEP,
      OP_MRG_DONE,
      OP_INS_INIT,
      OP_INS_RD,
      OP_INS_STEP,
      OP_INS_PUT,
      OP_POP_RD,
      OP_POP_STEP,
      OP_CLEAR,
      OP_SEND
   } dp_op_type;

   typedef struct packed {
      kind_type kind;
      logic     sel_main;
      logic     lo_lt_hi;
      logic     probe_eq;
      logic     stage_full;
      logic     merge_ovf;
      logic     s_zero;
      logic     p_zero;
      logic     ins_shift;
      logic     rsp_busy;
   } dp_stat_type;

endpackage

// ----- rtl/kss_if.sv -----
// ============================================================================
// Key set channels
// Request, response and register write channels with valid/ready handshake.
// ============================================================================
interface kss_req_if import kss_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [KEY_W-1:0]      key;
   logic [PAY_PORT_W-1:0] payload;

   modport source (output valid, kind, key, payload, input ready);
   modport sink (input valid, kind, key, payload, output ready);
endinterface

interface kss_rsp_if import kss_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [KEY_W-1:0]      out_key;
   logic [PAY_PORT_W-1:0] out_payload;
   logic [STATUS_W-1:0]   status;
   logic [TOTAL_W-1:0]    entry_total;

   modport source (output valid, found, out_key, out_payload, status, entry_total,
                   input ready);
   modport sink (input valid, found, out_key, out_payload, status, entry_total,
                 output ready);
endinterface

interface kss_csr_if import kss_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- rtl/kss_ctl.sv -----
// ============================================================================
// Key set controller
// Sequences searches, merges, sorted insertion, pops and clears over the datapath.
// ============================================================================
module kss_ctl import kss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  kind_type    req_kind,
   input  dp_stat_type stat,
   output logic        req_ready,
   output dp_op_type   op
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_kind) inside
                  KIND_INSERT, KIND_LOOKUP: state_in = S_SINIT;
                  KIND_POP:                 state_in = S_POP_RD;
                  default:                  state_in = S_CLEAR;
               endcase
            end
         end
         S_SINIT: state_in = S_PROBE;
         S_PROBE: begin
            if (stat.lo_lt_hi) begin
               state_in = S_STEP;
            end else if (!stat.sel_main) begin
               state_in = S_PROBE;
            end else if (stat.kind == KIND_LOOKUP) begin
               state_in = S_SEND;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_STEP: state_in = stat.probe_eq ? S_SEND : S_PROBE;
         S_CHECK: begin
            if (!stat.stage_full) begin
               state_in = S_INS_RD;
            end else if (stat.merge_ovf) begin
               state_in = S_SEND;
            end else begin
               state_in = S_MRG_RD;
            end
         end
         S_MRG_RD:   state_in = stat.s_zero ? S_CHECK : S_MRG_STEP;
         S_MRG_STEP: state_in = S_MRG_RD;
         S_INS_RD:   state_in = stat.p_zero ? S_SEND : S_INS_STEP;
         S_INS_STEP: state_in = stat.ins_shift ? S_INS_RD : S_SEND;
         S_POP_RD:   state_in = S_POP_STEP;
         S_POP_STEP: state_in = S_SEND;
         S_CLEAR:    state_in = S_SEND;
         S_SEND:     state_in = stat.rsp_busy ? S_SEND : S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op        = OP_IDLE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op = OP_LOAD;
            end
         end
         S_SINIT: op = OP_SINIT;
         S_PROBE: begin
            if (stat.lo_lt_hi) begin
               op = OP_PROBE;
            end else if (!stat.sel_main) begin
               op = OP_MINIT;
            end
         end
         S_STEP: op = OP_STEP;
         S_CHECK: begin
            if (!stat.stage_full) begin
               op = OP_INS_INIT;
            end else if (stat.merge_ovf) begin
               op = OP_FULL;
            end else begin
               op = OP_MRG_INIT;
            end
         end
         S_MRG_RD:   op = stat.s_zero ? OP_MRG_DONE : OP_MRG_RD;
         S_MRG_STEP: op = OP_MRG_STEP;
         S_INS_RD:   op = stat.p_zero ? OP_INS_PUT : OP_INS_RD;
         S_INS_STEP: op = OP_INS_STEP;
         S_POP_RD:   op = OP_POP_RD;
         S_POP_STEP: op = OP_POP_STEP;
         S_CLEAR:    op = OP_CLEAR;
         S_SEND:     op = stat.rsp_busy ? OP_IDLE : OP_SEND;
         default:    op = OP_IDLE;
      endcase
   end

endmodule

// ----- rtl/kss_dp.sv -----
// ============================================================================
// Key set datapath
// Staging and main memories, fill counts, search and merge indexes, results.
// ============================================================================
module kss_dp import kss_pkg::*; #(
   parameter int STAGE_DEPTH  = STAGE_DEPTH_DEF,
   parameter int MAIN_DEPTH   = MAIN_DEPTH_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_op_type   op,
   input  logic        req_ready,
   output dp_stat_type stat,
   kss_req_if.sink     req,
   kss_rsp_if.source   rsp,
   kss_csr_if.sink     csr
);

   localparam int SA_W  = $clog2(STAGE_DEPTH);
   localparam int SF_W  = $clog2(STAGE_DEPTH + 1);
   localparam int MA_W  = $clog2(MAIN_DEPTH);
   localparam int MF_W  = $clog2(MAIN_DEPTH + 1);
   localparam int IDX_W = (MF_W > SF_W) ? MF_W : SF_W;
   localparam int ENT_W = KEY_W + PAYLOAD_BITS;

   logic [ENT_W-1:0] stage_mem [STAGE_DEPTH];
   logic [ENT_W-1:0] main_mem [MAIN_DEPTH];

   kind_type                kind_ff, kind_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [LIMIT_W-1:0]      limit_ff, limit_in;
   logic [SF_W-1:0]         sf_ff, sf_in;
   logic [MF_W-1:0]         mf_ff, mf_in;
   logic [IDX_W-1:0]        lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic                    sel_main_ff, sel_main_in;
   logic [SF_W-1:0]         s_ff, s_in, p_ff, p_in;
   logic [MF_W-1:0]         m_ff, m_in, w_ff, w_in;
   logic                    res_found_ff, res_found_in;
   logic [KEY_W-1:0]        res_key_ff, res_key_in;
   logic [PAYLOAD_BITS-1:0] res_pay_ff, res_pay_in;
   status_type              res_status_ff, res_status_in;
   logic                    out_found_ff, out_found_in;
   logic [KEY_W-1:0]        out_key_ff, out_key_in;
   logic [PAYLOAD_BITS-1:0] out_pay_ff, out_pay_in;
   status_type              out_status_ff, out_status_in;
   logic [TOTAL_W-1:0]      out_total_ff, out_total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ENT_W-1:0]        stage_rd_ff, main_rd_ff;

   logic [SA_W-1:0]  stage_raddr, stage_waddr;
   logic [MA_W-1:0]  main_raddr, main_waddr;
   logic             stage_we, main_we;
   logic [ENT_W-1:0] stage_wdata, main_wdata;

   logic [IDX_W-1:0]        mid_calc;
   logic [ENT_W-1:0]        probe_rd;
   logic [KEY_W-1:0]        probe_key, stage_key, main_key;
   logic [SF_W-1:0]         s_dec, p_dec, sf_dec;
   logic [MF_W-1:0]         m_dec, w_dec, mf_dec;
   logic [31:0]             eff_lim;
   logic                    take_main, take_stage;

   assign mid_calc  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign probe_rd  = sel_main_ff ? main_rd_ff : stage_rd_ff;
   assign probe_key = probe_rd[ENT_W-1:PAYLOAD_BITS];
   assign stage_key = stage_rd_ff[ENT_W-1:PAYLOAD_BITS];
   assign main_key  = main_rd_ff[ENT_W-1:PAYLOAD_BITS];
   assign s_dec     = s_ff - SF_W'(1);
   assign p_dec     = p_ff - SF_W'(1);
   assign sf_dec    = sf_ff - SF_W'(1);
   assign m_dec     = m_ff - MF_W'(1);
   assign w_dec     = w_ff - MF_W'(1);
   assign mf_dec    = mf_ff - MF_W'(1);

   // A limit of zero acts as one, and anything above the depth as the depth.
   always_comb begin
      if (limit_ff == '0) begin
         eff_lim = 32'd1;
      end else if (32'(limit_ff) > 32'(STAGE_DEPTH)) begin
         eff_lim = 32'(STAGE_DEPTH);
      end else begin
         eff_lim = 32'(limit_ff);
      end
   end

   assign take_main  = (m_ff != '0) && (main_key > stage_key);
   assign take_stage = (sf_ff != '0) && ((mf_ff == '0) || (stage_key > main_key));

   assign stat.kind       = kind_ff;
   assign stat.sel_main   = sel_main_ff;
   assign stat.lo_lt_hi   = lo_ff < hi_ff;
   assign stat.probe_eq   = probe_key == key_ff;
   assign stat.stage_full = 32'(sf_ff) >= eff_lim;
   assign stat.merge_ovf  = (32'(sf_ff) + 32'(mf_ff)) > 32'(MAIN_DEPTH);
   assign stat.s_zero     = s_ff == '0;
   assign stat.p_zero     = p_ff == '0;
   assign stat.ins_shift  = stage_key > key_ff;
   assign stat.rsp_busy   = rsp_valid_ff;

   assign req.ready       = req_ready;
   assign csr.ready       = 1'b1;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.found       = out_found_ff;
   assign rsp.out_key     = out_key_ff;
   assign rsp.out_payload = PAY_PORT_W'(out_pay_ff);
   assign rsp.status      = out_status_ff;
   assign rsp.entry_total = out_total_ff;

   always_comb begin
      kind_in       = kind_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      limit_in      = (csr.valid) ? csr.data : limit_ff;
      sf_in         = sf_ff;
      mf_in         = mf_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      sel_main_in   = sel_main_ff;
      s_in          = s_ff;
      p_in          = p_ff;
      m_in          = m_ff;
      w_in          = w_ff;
      res_found_in  = res_found_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;
      res_status_in = res_status_ff;
      out_found_in  = out_found_ff;
      out_key_in    = out_key_ff;
      out_pay_in    = out_pay_ff;
      out_status_in = out_status_ff;
      out_total_in  = out_total_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp.ready;
      stage_raddr   = mid_calc[SA_W-1:0];
      main_raddr    = mid_calc[MA_W-1:0];
      stage_we      = 1'b0;
      stage_waddr   = p_ff[SA_W-1:0];
      stage_wdata   = {key_ff, pay_ff};
      main_we       = 1'b0;
      main_waddr    = w_dec[MA_W-1:0];
      main_wdata    = stage_rd_ff;

      unique case (op)
         OP_IDLE: begin
         end
         OP_LOAD: begin
            kind_in       = kind_type'(req.kind);
            key_in        = req.key;
            pay_in        = PAYLOAD_BITS'(req.payload);
            res_found_in  = 1'b0;
            res_key_in    = '0;
            res_pay_in    = '0;
            res_status_in = STATUS_OK;
         end
         OP_SINIT: begin
            lo_in       = '0;
            hi_in       = IDX_W'(sf_ff);
            sel_main_in = 1'b0;
         end
         OP_MINIT: begin
            lo_in       = '0;
            hi_in       = IDX_W'(mf_ff);
            sel_main_in = 1'b1;
         end
         OP_PROBE: begin
            mid_in = mid_calc;
         end
         OP_STEP: begin
            if (probe_key == key_ff) begin
               res_found_in = 1'b1;
               res_key_in   = probe_key;
               res_pay_in   = probe_rd[PAYLOAD_BITS-1:0];
            end else if (probe_key > key_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + IDX_W'(1);
            end
         end
         OP_FULL: begin
            res_status_in = STATUS_FULL;
         end
         OP_MRG_INIT: begin
            s_in = sf_ff;
            m_in = mf_ff;
            w_in = MF_W'(32'(sf_ff) + 32'(mf_ff));
         end
         OP_MRG_RD: begin
            stage_raddr = s_dec[SA_W-1:0];
            main_raddr  = m_dec[MA_W-1:0];
         end
         OP_MRG_STEP: begin
            main_we    = 1'b1;
            main_wdata = take_main ? main_rd_ff : stage_rd_ff;
            w_in       = w_dec;
            if (take_main) begin
               m_in = m_dec;
            end else begin
               s_in = s_dec;
            end
         end
         OP_MRG_DONE: begin
            mf_in = mf_ff + MF_W'(sf_ff);
            sf_in = '0;
         end
         OP_INS_INIT: begin
            p_in = sf_ff;
         end
         OP_INS_RD: begin
            stage_raddr = p_dec[SA_W-1:0];
         end
         OP_INS_STEP: begin
            stage_we = 1'b1;
            if (stage_key > key_ff) begin
               stage_wdata = stage_rd_ff;
               p_in        = p_dec;
            end else begin
               sf_in = sf_ff + SF_W'(1);
            end
         end
         OP_INS_PUT: begin
            stage_we = 1'b1;
            sf_in    = sf_ff + SF_W'(1);
         end
         OP_POP_RD: begin
            stage_raddr = sf_dec[SA_W-1:0];
            main_raddr  = mf_dec[MA_W-1:0];
         end
         OP_POP_STEP: begin
            if (take_stage) begin
               sf_in      = sf_dec;
               res_key_in = stage_key;
               res_pay_in = stage_rd_ff[PAYLOAD_BITS-1:0];
            end else if (mf_ff != '0) begin
               mf_in      = mf_dec;
               res_key_in = main_key;
               res_pay_in = main_rd_ff[PAYLOAD_BITS-1:0];
            end else begin
               res_status_in = STATUS_EMPTY;
            end
         end
         OP_CLEAR: begin
            sf_in = '0;
            mf_in = '0;
         end
         OP_SEND: begin
            out_found_in  = res_found_ff;
            out_key_in    = res_key_ff;
            out_pay_in    = res_pay_ff;
            out_status_in = res_status_ff;
            out_total_in  = TOTAL_W'(32'(sf_ff) + 32'(mf_ff));
            rsp_valid_in  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_W'(LIMIT_RESET);
         sf_ff        <= '0;
         mf_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         sf_ff        <= sf_in;
         mf_ff        <= mf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      sel_main_ff   <= sel_main_in;
      s_ff          <= s_in;
      p_ff          <= p_in;
      m_ff          <= m_in;
      w_ff          <= w_in;
      res_found_ff  <= res_found_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
      res_status_ff <= res_status_in;
      out_found_ff  <= out_found_in;
      out_key_ff    <= out_key_in;
      out_pay_ff    <= out_pay_in;
      out_status_ff <= out_status_in;
      out_total_ff  <= out_total_in;
   end

   always_ff @(posedge clock) begin
      if (stage_we) begin
         stage_mem[stage_waddr] <= stage_wdata;
      end
      stage_rd_ff <= stage_mem[stage_raddr];
   end

   always_ff @(posedge clock) begin
      if (main_we) begin
         main_mem[main_waddr] <= main_wdata;
      end
      main_rd_ff <= main_mem[main_raddr];
   end

endmodule

// ----- rtl/two_level_sorted_key_set_unit.sv -----
// ============================================================================
// Two-level sorted key set unit
// Keeps distinct keys with payloads in a sorted staging memory and a sorted
// main memory; supports insert, lookup, pop of the largest key and clear.
// ============================================================================
// Operation: a lookup is a binary search over the staging entries and, on a
// miss, the main entries, at most 5 staging and 11 main probes by default.
// An insert that misses then shifts the larger staging entries up one by one,
// and a full staging memory is first merged into main from the top down. One
// item is in work at a time; each probe, shift and merge step is a registered
// memory read followed by a compare.
// Reset clears the fill counts and sets the staging limit to 16; memories
// need no clearing pass, since only entries below the fill counts are used.
module two_level_sorted_key_set_unit import kss_pkg::*; #(
   parameter int STAGE_DEPTH  = STAGE_DEPTH_DEF,
   parameter int MAIN_DEPTH   = MAIN_DEPTH_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   kss_req_if.sink   req_bus,
   kss_rsp_if.source rsp_bus,
   kss_csr_if.sink   csr_bus
);

   // The controller owns sequencing; the datapath owns all storage and
   // reports comparisons back as a status word.
   dp_op_type   op;
   dp_stat_type stat;
   logic        req_ready;

   kss_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (kind_type'(req_bus.kind)),
      .stat      (stat),
      .req_ready (req_ready),
      .op        (op)
   );

   // The response sits in an output register, so the next item is taken
   // while an earlier result still waits for the sink.
   kss_dp #(
      .STAGE_DEPTH  (STAGE_DEPTH),
      .MAIN_DEPTH   (MAIN_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_ready (req_ready),
      .stat      (stat),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr       (csr_bus)
   );

endmodule
